>>> design/pppoe_passthrough_mac_learning_unit_macros.svh
// Assertion helpers shared by the RTL files.
// Every use expects clk_i and rst_ni in scope.
`ifndef PPPOE_PASSTHROUGH_MAC_LEARNING_UNIT_MACROS_SVH
`define PPPOE_PASSTHROUGH_MAC_LEARNING_UNIT_MACROS_SVH

// Property checked on every rising edge outside reset.
`define PPML_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define PPML_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

>>> design/ppml_pkg.sv
`default_nettype none

package ppml_pkg;

  // Learned source table
  localparam int TABLE_DEPTH = 16;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // Queue between classifier and table engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Field widths
  localparam int MAC_W   = 48;
  localparam int PORT_W  = 4;
  localparam int ETYPE_W = 16;
  localparam int ACT_W   = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 48;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LAN_PORT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WAN_PORT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WAN_MAC  = 2'd3;

  // PPPoE ethertypes
  localparam logic [ETYPE_W-1:0] ETH_PPP_SES  = 16'h8864;
  localparam logic [ETYPE_W-1:0] ETH_PPP_DISC = 16'h8863;

  // Item kind
  localparam logic KIND_FRAME = 1'b0;
  localparam logic KIND_CLEAR = 1'b1;

  typedef enum logic [ACT_W-1:0] {
    ACT_NONE = 2'd0,
    ACT_WAN  = 2'd1,
    ACT_LAN  = 2'd2
  } act_e;

  // What the table engine has to do with a beat
  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_PASS,
    OP_LAN,
    OP_WAN
  } op_e;

  typedef struct packed {
    logic              enable;
    logic [PORT_W-1:0] lan_port;
    logic [PORT_W-1:0] wan_port;
    logic [MAC_W-1:0]  wan_mac;
  } cfg_t;

  typedef struct packed {
    op_e              op;
    logic [MAC_W-1:0] key;
  } cmd_t;

  typedef struct packed {
    logic push;
    logic pop;
  } q_ctrl_t;

endpackage

`default_nettype wire

>>> design/ppml_in_if.sv
`default_nettype none

interface ppml_in_if import ppml_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [ETYPE_W-1:0] ether_type;
  logic [PORT_W-1:0]  ingress_port;
  logic [MAC_W-1:0]   dest_mac;
  logic [MAC_W-1:0]   src_mac;

  modport source (output valid, kind, ether_type, ingress_port, dest_mac, src_mac,
                  input ready);
  modport sink   (input valid, kind, ether_type, ingress_port, dest_mac, src_mac,
                  output ready);
endinterface

`default_nettype wire

>>> design/ppml_out_if.sv
`default_nettype none

interface ppml_out_if import ppml_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ACT_W-1:0]  action;
  logic [PORT_W-1:0] egress_port;
  logic              learned;
  logic              table_full;

  modport source (output valid, action, egress_port, learned, table_full,
                  input ready);
  modport sink   (input valid, action, egress_port, learned, table_full,
                  output ready);
endinterface

`default_nettype wire

>>> design/ppml_cfg_if.sv
`default_nettype none

interface ppml_cfg_if import ppml_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] wdata;

  modport source (output valid, index, wdata, input ready);
  modport sink   (input valid, index, wdata, output ready);
endinterface

`default_nettype wire

>>> design/ppml_cfg_regs.sv
`default_nettype none

module ppml_cfg_regs import ppml_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  ppml_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Writes are always taken
  assign cfg_i.ready = 1'b1;

  // Register decode
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_ENABLE:   cfg_d.enable   = cfg_i.wdata[0];
        CFG_LAN_PORT: cfg_d.lan_port = cfg_i.wdata[PORT_W-1:0];
        CFG_WAN_PORT: cfg_d.wan_port = cfg_i.wdata[PORT_W-1:0];
        CFG_WAN_MAC:  cfg_d.wan_mac  = cfg_i.wdata[MAC_W-1:0];
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable   <= 1'b0;
      cfg_q.lan_port <= PORT_W'(0);
      cfg_q.wan_port <= PORT_W'(1);
      cfg_q.wan_mac  <= MAC_W'(0);
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> design/ppml_front.sv
`default_nettype none

module ppml_front import ppml_pkg::*; (
  ppml_in_if.sink in_i,
  input  cfg_t    cfg_i,
  input  logic    q_full_i,
  output logic    push_o,
  output cmd_t    cmd_o
);

  logic is_pppoe;

  // Take a beat whenever the queue has room
  assign in_i.ready = !q_full_i;
  assign push_o     = in_i.valid && !q_full_i;

  assign is_pppoe = (in_i.ether_type == ETH_PPP_SES) || (in_i.ether_type == ETH_PPP_DISC);

  // Classify: LAN wins when both ports are the same
  always_comb begin
    cmd_o.op  = OP_PASS;
    cmd_o.key = in_i.src_mac;
    if (in_i.kind == KIND_CLEAR) begin
      cmd_o.op = OP_CLEAR;
    end else if (cfg_i.enable && is_pppoe) begin
      if (in_i.ingress_port == cfg_i.lan_port) begin
        // own WAN address seen on the LAN side is passed without learning
        if (in_i.src_mac != cfg_i.wan_mac) begin
          cmd_o.op = OP_LAN;
        end
      end else if (in_i.ingress_port == cfg_i.wan_port) begin
        cmd_o.op  = OP_WAN;
        cmd_o.key = in_i.dest_mac;
      end
    end
  end

endmodule

`default_nettype wire

>>> design/ppml_queue.sv
`default_nettype none

`include "pppoe_passthrough_mac_learning_unit_macros.svh"

module ppml_queue import ppml_pkg::*; (
  input  wire     clk_i,
  input  wire     rst_ni,
  input  q_ctrl_t ctrl_i,
  input  cmd_t    cmd_i,
  output cmd_t    cmd_o,
  output logic    full_o,
  output logic    empty_o
);

  cmd_t              slot_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] fill_q, fill_d;

  function automatic logic [QPTR_W-1:0] ptr_inc(logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? QPTR_W'(0) : p + QPTR_W'(1);
  endfunction

  assign full_o  = (fill_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (fill_q == QCNT_W'(0));
  assign cmd_o   = slot_q[rd_ptr_q];

  // Pointer and fill bookkeeping
  always_comb begin
    wr_ptr_d = ctrl_i.push ? ptr_inc(wr_ptr_q) : wr_ptr_q;
    rd_ptr_d = ctrl_i.pop  ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    fill_d   = fill_q;
    if (ctrl_i.push && !ctrl_i.pop) begin
      fill_d = fill_q + QCNT_W'(1);
    end else if (!ctrl_i.push && ctrl_i.pop) begin
      fill_d = fill_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= QPTR_W'(0);
      rd_ptr_q <= QPTR_W'(0);
      fill_q   <= QCNT_W'(0);
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  `PPML_ASSERT_NEVER(a_no_push_full, ctrl_i.push && full_o && !ctrl_i.pop, "push into full queue")
  `PPML_ASSERT_NEVER(a_no_pop_empty, ctrl_i.pop && empty_o, "pop from empty queue")
  `PPML_ASSERT(a_fill_bound, fill_q <= QCNT_W'(QUEUE_DEPTH), "queue fill out of range")

endmodule

`default_nettype wire

>>> design/ppml_back.sv
`default_nettype none

`include "pppoe_passthrough_mac_learning_unit_macros.svh"

module ppml_back import ppml_pkg::*; (
  input  wire         clk_i,
  input  wire         rst_ni,
  input  cfg_t        cfg_i,
  input  cmd_t        cmd_i,
  input  logic        q_empty_i,
  output logic        pop_o,
  ppml_out_if.source  out_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_DONE
  } state_e;

  state_e            state_q;
  cmd_t              cmd_q;
  logic              hit_q;
  logic [CNT_W-1:0]  count_q;
  logic [MAC_W-1:0]  table_q [TABLE_DEPTH];

  logic              out_valid_q;
  act_e              act_q;
  logic [PORT_W-1:0] egress_q;
  logic              learned_q;
  logic              full_q;

  logic              hit_d;
  logic              commit;
  logic              is_full;
  logic              learn;
  act_e              act_d;
  logic [PORT_W-1:0] egress_d;
  logic              full_d;

  assign pop_o   = (state_q == S_IDLE) && !q_empty_i;
  assign commit  = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign is_full = (count_q == CNT_W'(TABLE_DEPTH));
  assign learn   = (cmd_q.op == OP_LAN) && !hit_q && !is_full;

  // Compare the key against every live entry
  always_comb begin
    hit_d = 1'b0;
    for (int k = 0; k < TABLE_DEPTH; k++) begin
      if ((CNT_W'(k) < count_q) && (table_q[k] == cmd_q.key)) begin
        hit_d = 1'b1;
      end
    end
  end

  // Result of the beat in flight
  always_comb begin
    act_d    = ACT_NONE;
    egress_d = PORT_W'(0);
    full_d   = 1'b0;
    case (cmd_q.op)
      OP_LAN: begin
        act_d    = ACT_WAN;
        egress_d = cfg_i.wan_port;
        full_d   = !hit_q && is_full;
      end
      OP_WAN: begin
        if (hit_q) begin
          act_d    = ACT_LAN;
          egress_d = cfg_i.lan_port;
        end
      end
      default: begin
        act_d = ACT_NONE;
      end
    endcase
  end

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '{op: OP_PASS, key: MAC_W'(0)};
      hit_q       <= 1'b0;
      count_q     <= CNT_W'(0);
      out_valid_q <= 1'b0;
      act_q       <= ACT_NONE;
      egress_q    <= PORT_W'(0);
      learned_q   <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            cmd_q   <= cmd_i;
            state_q <= S_MATCH;
          end
        end
        S_MATCH: begin
          hit_q   <= hit_d;
          state_q <= S_DONE;
        end
        S_DONE: begin
          if (commit) begin
            act_q       <= act_d;
            egress_q    <= egress_d;
            learned_q   <= learn;
            full_q      <= full_d;
            if (cmd_q.op == OP_CLEAR) begin
              count_q <= CNT_W'(0);
            end else if (learn) begin
              count_q <= count_q + CNT_W'(1);
            end
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  // Table storage, contents undefined after reset
  always_ff @(posedge clk_i) begin
    if (commit && learn) begin
      table_q[count_q[IDX_W-1:0]] <= cmd_q.key;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.action      = act_q;
  assign out_o.egress_port = egress_q;
  assign out_o.learned     = learned_q;
  assign out_o.table_full  = full_q;

  `PPML_ASSERT(a_count_bound, count_q <= CNT_W'(TABLE_DEPTH), "entry count above depth")
  `PPML_ASSERT_NEVER(a_learn_and_full, out_valid_q && learned_q && full_q, "learned with full")
  `PPML_ASSERT(a_learn_grows, commit && learn |=> count_q == $past(count_q) + CNT_W'(1),
               "learn did not grow table")
  `PPML_ASSERT(a_clear_empties, commit && (cmd_q.op == OP_CLEAR) |=> count_q == CNT_W'(0),
               "clear left entries")

endmodule

`default_nettype wire

>>> design/pppoe_passthrough_mac_learning_unit.sv
// Channel   Dir  Beat carries
// --------  ---  -------------------------------------------------------
// in_i      in   kind, ether_type, ingress_port, dest_mac, src_mac
// cfg_i     in   index, wdata (enable, lan_port, wan_port, wan_mac)
// out_o     out  action, egress_port, learned, table_full
//
// An input beat is classified and queued in the cycle it is accepted; the queue holds two.
// The table engine works through three steps per beat: dequeue, parallel compare against all
// learned entries, then commit of table update and result.
// The engine takes a new beat from the queue only after the last one has committed.
// Reset sets config defaults, clears entry count and all handshake state, not table entries.
// A stalled output holds its result register and the engine waits; input stays open until
// the queue holds two beats.
`default_nettype none

module pppoe_passthrough_mac_learning_unit import ppml_pkg::*; (
  input  wire        clk_i,
  input  wire        rst_ni,
  ppml_in_if.sink    in_i,
  ppml_cfg_if.sink   cfg_i,
  ppml_out_if.source out_o
);

  cfg_t    cfg;
  cmd_t    cmd_in;
  cmd_t    cmd_out;
  q_ctrl_t q_ctrl;
  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;

  assign q_ctrl = '{push: q_push, pop: q_pop};

  ppml_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  ppml_front u_front (
    .in_i     (in_i),
    .cfg_i    (cfg),
    .q_full_i (q_full),
    .push_o   (q_push),
    .cmd_o    (cmd_in)
  );

  ppml_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (q_ctrl),
    .cmd_i   (cmd_in),
    .cmd_o   (cmd_out),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  ppml_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .cmd_i     (cmd_out),
    .q_empty_i (q_empty),
    .pop_o     (q_pop),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire
